>>> rtl/core/pra_pkg.sv
// Shared types and constants for the pixel rotation address generator.
package pra_pkg;

  // Field and datapath widths
  localparam int unsigned COORD_W    = 13;  // column and row counters
  localparam int unsigned DIM_W      = 14;  // width and height registers
  localparam int unsigned TRIG_W     = 16;  // cosine and sine, Q2.14
  localparam int unsigned OFS_W      = 29;  // bounding-box offsets, Q.14
  localparam int unsigned FRAC_BITS  = 14;  // fraction bits of the trig values
  localparam int unsigned PROD_W     = COORD_W + 1 + TRIG_W;
  localparam int unsigned SUM_W      = 32;
  localparam int unsigned SCL_W      = SUM_W - FRAC_BITS;
  localparam int unsigned STRIDE_W   = 16;
  localparam int unsigned XBYTE_W    = 16;
  localparam int unsigned YPROD_W    = DIM_W + STRIDE_W;
  localparam int unsigned ADDR_W     = 28;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned PIX_W      = 3 * BYTE_W;
  localparam int unsigned OUT_DATA_W = 56;
  localparam int unsigned OUT_PAD_W  = OUT_DATA_W - ADDR_W - PIX_W;

  // Rounding bias that turns a floor shift into truncation toward zero
  localparam logic signed [SUM_W-1:0] TRUNC_BIAS = SUM_W'((1 << FRAC_BITS) - 1);

  // Queue between front and back
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 29;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COS        = 3'd0,
    CFG_SIN        = 3'd1,
    CFG_X_OFFSET   = 3'd2,
    CFG_Y_OFFSET   = 3'd3,
    CFG_SRC_WIDTH  = 3'd4,
    CFG_SRC_HEIGHT = 3'd5,
    CFG_DST_WIDTH  = 3'd6,
    CFG_DST_HEIGHT = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic signed [TRIG_W-1:0] cos_value;
    logic signed [TRIG_W-1:0] sin_value;
    logic signed [OFS_W-1:0]  x_offset;
    logic signed [OFS_W-1:0]  y_offset;
    logic [DIM_W-1:0]         src_width;
    logic [DIM_W-1:0]         src_height;
    logic [DIM_W-1:0]         dst_width;
    logic [DIM_W-1:0]         dst_height;
  } pra_cfg_t;

  // One classified source pixel
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [PIX_W-1:0]   pix;
    logic               last;
  } pra_item_t;

endpackage

>>> rtl/core/pra_front.sv
// Front end: accepts source pixels, tracks raster position, marks frame end.
module pra_front
  import pra_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pra_cfg_t         cfg_i,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [PIX_W-1:0] s_axis_tdata_i,
  input  logic             full_i,
  output logic             push_o,
  output pra_item_t        item_o
);

  logic [COORD_W-1:0] col_q, col_d;
  logic [COORD_W-1:0] row_q, row_d;
  logic               row_end;
  logic               frame_end;

  // Classify the current position
  assign row_end   = (DIM_W'(col_q) + DIM_W'(1)) >= cfg_i.src_width;
  assign frame_end = row_end && ((DIM_W'(row_q) + DIM_W'(1)) >= cfg_i.src_height);

  assign s_axis_tready_o = !full_i;
  assign push_o          = s_axis_tvalid_i && !full_i;

  always_comb begin
    item_o.x    = col_q;
    item_o.y    = row_q;
    item_o.pix  = s_axis_tdata_i;
    item_o.last = frame_end;
  end

  // Advance counters on each transfer; counters wrap at their width
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (push_o) begin
      if (row_end) begin
        col_d = '0;
        row_d = frame_end ? '0 : row_q + COORD_W'(1);
      end else begin
        col_d = col_q + COORD_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // A frame-end pixel restarts the raster at the origin
  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && item_o.last |=> col_q == '0 && row_q == '0)
    else $error("counters not cleared after frame end");

endmodule

>>> rtl/core/pra_fifo.sv
// Short queue that decouples the pixel front end from the address pipeline.
module pra_fifo
  import pra_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  pra_item_t item_i,
  output logic      full_o,
  input  logic      pop_i,
  output pra_item_t item_o,
  output logic      empty_o
);

  pra_item_t          slot_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CW-1:0] cnt_q;

  assign full_o  = cnt_q == FIFO_CW'(FIFO_DEPTH);
  assign empty_o = cnt_q == '0;
  assign item_o  = slot_q[rd_ptr_q];

  // Store pushed items
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

  // Move pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
      if (push_i && !pop_i)      cnt_q <= cnt_q + FIFO_CW'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - FIFO_CW'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");

endmodule

>>> rtl/core/pra_back.sv
// Back end: rotates coordinates, checks range and forms the byte address.
module pra_back
  import pra_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pra_cfg_t              cfg_i,
  input  logic                  empty_i,
  input  pra_item_t             item_i,
  output logic                  pop_o,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  output logic [0:0]            m_axis_tuser_o,
  output logic                  m_axis_tlast_o
);

  logic en;

  // Stage 1: products
  logic                     s1_vld_q;
  logic signed [PROD_W-1:0] s1_xc_q, s1_ys_q, s1_xs_q, s1_yc_q;
  logic [PIX_W-1:0]         s1_pix_q;
  logic                     s1_last_q;
  logic signed [PROD_W-1:0] xc_d, ys_d, xs_d, yc_d;

  // Stage 2: rotated fixed-point sums
  logic                    s2_vld_q;
  logic signed [SUM_W-1:0] s2_sx_q, s2_sy_q;
  logic [PIX_W-1:0]        s2_pix_q;
  logic                    s2_last_q;
  logic signed [SUM_W-1:0] sx_d, sy_d;

  // Stage 3: integer coordinates and range flag
  logic                    s3_vld_q;
  logic [DIM_W-1:0]        s3_xd_q, s3_yd_q;
  logic                    s3_ok_q;
  logic [PIX_W-1:0]        s3_pix_q;
  logic                    s3_last_q;
  logic signed [SUM_W-1:0] bx, by;
  logic signed [SCL_W-1:0] xd, yd;
  logic                    ok_d;

  // Stage 4: address terms
  logic                 s4_vld_q;
  logic [YPROD_W-1:0]   s4_yprod_q;
  logic [XBYTE_W-1:0]   s4_xbyte_q;
  logic                 s4_ok_q;
  logic [PIX_W-1:0]     s4_pix_q;
  logic                 s4_last_q;
  logic [STRIDE_W-1:0]  row_bytes, stride;
  logic [ADDR_W-1:0]    addr_d;

  // Output register
  logic              out_vld_q;
  logic [ADDR_W-1:0] out_addr_q;
  logic [PIX_W-1:0]  out_pix_q;
  logic              out_ok_q;
  logic              out_last_q;

  // Whole pipeline moves when the output slot is free or being taken
  assign en    = !out_vld_q || m_axis_tready_i;
  assign pop_o = en && !empty_i;

  // Forward rotation products
  always_comb begin
    xc_d = $signed({1'b0, item_i.x}) * cfg_i.cos_value;
    ys_d = $signed({1'b0, item_i.y}) * cfg_i.sin_value;
    xs_d = $signed({1'b0, item_i.x}) * cfg_i.sin_value;
    yc_d = $signed({1'b0, item_i.y}) * cfg_i.cos_value;
  end

  // Subtract bounding-box offsets
  always_comb begin
    sx_d = SUM_W'(s1_xc_q) - SUM_W'(s1_ys_q) - SUM_W'(cfg_i.x_offset);
    sy_d = SUM_W'(s1_xs_q) + SUM_W'(s1_yc_q) - SUM_W'(cfg_i.y_offset);
  end

  // Truncate toward zero and check the destination bounds
  always_comb begin
    bx   = s2_sx_q + (s2_sx_q[SUM_W-1] ? TRUNC_BIAS : '0);
    by   = s2_sy_q + (s2_sy_q[SUM_W-1] ? TRUNC_BIAS : '0);
    xd   = bx[SUM_W-1:FRAC_BITS];
    yd   = by[SUM_W-1:FRAC_BITS];
    ok_d = !xd[SCL_W-1] && !yd[SCL_W-1] &&
           (SCL_W'(xd) < SCL_W'(cfg_i.dst_width)) &&
           (SCL_W'(yd) < SCL_W'(cfg_i.dst_height));
  end

  // Row stride padded to a multiple of four bytes
  always_comb begin
    row_bytes = STRIDE_W'(cfg_i.dst_width) * STRIDE_W'(3);
    stride    = (row_bytes + STRIDE_W'(3)) & ~STRIDE_W'(3);
  end

  // Final address, zero when out of range
  assign addr_d = s4_ok_q ?
                  ADDR_W'(s4_yprod_q) + ADDR_W'(s4_xbyte_q) : '0;

  // Stage valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q  <= pop_o;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      s4_vld_q  <= s3_vld_q;
      out_vld_q <= s4_vld_q;
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_xc_q    <= xc_d;
      s1_ys_q    <= ys_d;
      s1_xs_q    <= xs_d;
      s1_yc_q    <= yc_d;
      s1_pix_q   <= item_i.pix;
      s1_last_q  <= item_i.last;

      s2_sx_q    <= sx_d;
      s2_sy_q    <= sy_d;
      s2_pix_q   <= s1_pix_q;
      s2_last_q  <= s1_last_q;

      s3_xd_q    <= DIM_W'(xd);
      s3_yd_q    <= DIM_W'(yd);
      s3_ok_q    <= ok_d;
      s3_pix_q   <= s2_pix_q;
      s3_last_q  <= s2_last_q;

      s4_yprod_q <= YPROD_W'(s3_yd_q) * YPROD_W'(stride);
      s4_xbyte_q <= XBYTE_W'(s3_xd_q) * XBYTE_W'(3);
      s4_ok_q    <= s3_ok_q;
      s4_pix_q   <= s3_pix_q;
      s4_last_q  <= s3_last_q;

      out_addr_q <= addr_d;
      out_pix_q  <= s4_pix_q;
      out_ok_q   <= s4_ok_q;
      out_last_q <= s4_last_q;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {OUT_PAD_W'(0), out_pix_q, out_addr_q};
  assign m_axis_tuser_o  = out_ok_q;
  assign m_axis_tlast_o  = out_last_q;

  a_oob_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_ok_q |-> out_addr_q == '0)
    else $error("nonzero address on out-of-range pixel");

endmodule

>>> rtl/core/pixel_rotation_address_generator.sv
// Top level: configuration registers, front end, queue and address pipeline.
//
// Takes one 24-bit source pixel per transfer in raster order and returns, for
// each, the byte address of its forward-rotated position in a destination
// image whose rows are padded to four bytes, the three bytes unchanged, an
// in-range flag (tuser) and a frame-end mark (tlast). Out-of-range pixels
// carry address zero and should be dropped by the writer. The block sustains
// one pixel per clock while the output is not stalled; a result passes
// through the four-entry queue, then the four product, sum, truncation and
// address stages into the output register. An output stall freezes the
// whole pipeline and the queue takes up to four more pixels before the input
// stalls. Write configuration only while idle.
module pixel_rotation_address_generator
  import pra_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // source pixels
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [PIX_W-1:0]      s_axis_tdata_i,  // byte0, byte1, byte2
  // destination results
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,  // dest_address, out_byte0..2, pad
  output logic [0:0]            m_axis_tuser_o,  // in_range
  output logic                  m_axis_tlast_o   // last_pixel
);

  pra_cfg_t  cfg_q;
  logic      push, full, pop, empty;
  pra_item_t push_item, pop_item;

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cos_value  <= TRIG_W'(1 << FRAC_BITS);
      cfg_q.sin_value  <= '0;
      cfg_q.x_offset   <= '0;
      cfg_q.y_offset   <= '0;
      cfg_q.src_width  <= DIM_W'(1);
      cfg_q.src_height <= DIM_W'(1);
      cfg_q.dst_width  <= DIM_W'(1);
      cfg_q.dst_height <= DIM_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_COS:        cfg_q.cos_value  <= cfg_data_i[TRIG_W-1:0];
        CFG_SIN:        cfg_q.sin_value  <= cfg_data_i[TRIG_W-1:0];
        CFG_X_OFFSET:   cfg_q.x_offset   <= cfg_data_i[OFS_W-1:0];
        CFG_Y_OFFSET:   cfg_q.y_offset   <= cfg_data_i[OFS_W-1:0];
        CFG_SRC_WIDTH:  cfg_q.src_width  <= cfg_data_i[DIM_W-1:0];
        CFG_SRC_HEIGHT: cfg_q.src_height <= cfg_data_i[DIM_W-1:0];
        CFG_DST_WIDTH:  cfg_q.dst_width  <= cfg_data_i[DIM_W-1:0];
        CFG_DST_HEIGHT: cfg_q.dst_height <= cfg_data_i[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  pra_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .full_i          (full),
    .push_o          (push),
    .item_o          (push_item)
  );

  pra_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .item_o  (pop_item),
    .empty_o (empty)
  );

  pra_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .empty_i         (empty),
    .item_i          (pop_item),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

>>> tb/tb.sv
// Self-checking testbench for the pixel rotation address generator.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pra_pkg::*;

  localparam longint     TRIG_ONE    = longint'(1) << FRAC_BITS;
  localparam real        PI          = 3.14159265358979323846;
  localparam int         RAND_ITEMS  = 1350;
  localparam int         CALM_ITEMS  = 150;
  localparam longint     CYCLE_LIMIT = 3000000;
  localparam int         MAX_REPORTS = 200;
  localparam logic [DIM_W-1:0] DIM_MAX = '1;

  // One expected or observed result, one field per member
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] b0;
    logic [BYTE_W-1:0] b1;
    logic [BYTE_W-1:0] b2;
    logic              in_range;
    logic              last;
  } pix_result_t;

  // One row of the directed table: a register write or a pixel
  typedef struct {
    bit               is_write;
    cfg_reg_e         reg_idx;
    longint           value;
    logic [PIX_W-1:0] pix;
    bit               typed;
    pix_result_t      want;
  } stim_row_t;

  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;
  logic                  cfg_we    = 1'b0;
  cfg_reg_e              cfg_idx   = CFG_COS;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  src_valid = 1'b0;
  logic                  src_ready;
  logic [PIX_W-1:0]      src_data  = '0;
  logic                  res_valid;
  logic                  res_ready = 1'b0;
  logic [OUT_DATA_W-1:0] res_data;
  logic [0:0]            res_user;
  logic                  res_last;

  // Typed expectation that travels with a directed pixel
  bit          row_typed = 1'b0;
  pix_result_t row_want  = '0;

  // Mirror of the block: registers and raster counters
  logic signed [TRIG_W-1:0] rot_cos = 16'sd16384;
  logic signed [TRIG_W-1:0] rot_sin = '0;
  logic signed [OFS_W-1:0]  ofs_x   = '0;
  logic signed [OFS_W-1:0]  ofs_y   = '0;
  logic [DIM_W-1:0]         src_w   = 14'd1;
  logic [DIM_W-1:0]         src_h   = 14'd1;
  logic [DIM_W-1:0]         dst_w   = 14'd1;
  logic [DIM_W-1:0]         dst_h   = 14'd1;
  logic [COORD_W-1:0]       col     = '0;
  logic [COORD_W-1:0]       row     = '0;

  pix_result_t dest_q[$];
  stim_row_t   table_q[$];
  int unsigned n_sent = 0;
  int unsigned n_done = 0;
  int unsigned errors = 0;
  longint      cycles = 0;
  bit          calm = 1'b0;
  int          gap_pct = 0;
  int          stall_pct = 0;

  pixel_rotation_address_generator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (src_valid),
    .s_axis_tready_o (src_ready),
    .s_axis_tdata_i  (src_data),
    .m_axis_tvalid_o (res_valid),
    .m_axis_tready_i (res_ready),
    .m_axis_tdata_o  (res_data),
    .m_axis_tuser_o  (res_user),
    .m_axis_tlast_o  (res_last)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Rotate the current source coordinates, form the address, advance the raster
  function automatic pix_result_t map_pixel(input logic [PIX_W-1:0] pix);
    longint      xq, yq, xd, yd, stride;
    bit          row_end, frame_end;
    pix_result_t r;
    xq = longint'(col) * rot_cos - longint'(row) * rot_sin - ofs_x;
    yq = longint'(col) * rot_sin + longint'(row) * rot_cos - ofs_y;
    // signed division truncates toward zero
    xd = xq / TRIG_ONE;
    yd = yq / TRIG_ONE;
    r.b0 = pix[BYTE_W-1:0];
    r.b1 = pix[BYTE_W +: BYTE_W];
    r.b2 = pix[2*BYTE_W +: BYTE_W];
    r.in_range = xd >= 0 && yd >= 0 && xd < longint'(dst_w) && yd < longint'(dst_h);
    r.addr = '0;
    if (r.in_range) begin
      stride = (longint'(dst_w) * 3 + 3) & ~longint'(3);
      r.addr = ADDR_W'(xd * 3 + yd * stride);
    end
    row_end   = int'(col) + 1 >= int'(src_w);
    frame_end = row_end && int'(row) + 1 >= int'(src_h);
    r.last = frame_end;
    // counters wrap at their own width
    if (row_end) begin
      col = '0;
      row = frame_end ? '0 : row + 1'b1;
    end else begin
      col = col + 1'b1;
    end
    return r;
  endfunction

  task automatic check_field(input string what, input longint unsigned want_v,
                             input longint unsigned got_v);
    if (want_v != got_v) begin
      if (errors < MAX_REPORTS)
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want_v, got_v);
      errors++;
    end
  endtask

  // Mirror register writes, predict accepted pixels, check accepted results
  always @(posedge clk_i) begin : scoreboard
    pix_result_t want, got;
    if (rst_ni) begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_COS:        rot_cos = cfg_data[TRIG_W-1:0];
          CFG_SIN:        rot_sin = cfg_data[TRIG_W-1:0];
          CFG_X_OFFSET:   ofs_x   = cfg_data[OFS_W-1:0];
          CFG_Y_OFFSET:   ofs_y   = cfg_data[OFS_W-1:0];
          CFG_SRC_WIDTH:  src_w   = cfg_data[DIM_W-1:0];
          CFG_SRC_HEIGHT: src_h   = cfg_data[DIM_W-1:0];
          CFG_DST_WIDTH:  dst_w   = cfg_data[DIM_W-1:0];
          CFG_DST_HEIGHT: dst_h   = cfg_data[DIM_W-1:0];
        endcase
      end
      if (src_valid && src_ready) begin
        want = map_pixel(src_data);
        if (row_typed)
          want = row_want;
        dest_q.push_back(want);
      end
      if (res_valid && res_ready) begin
        got.addr     = res_data[ADDR_W-1:0];
        got.b0       = res_data[ADDR_W +: BYTE_W];
        got.b1       = res_data[ADDR_W+BYTE_W +: BYTE_W];
        got.b2       = res_data[ADDR_W+2*BYTE_W +: BYTE_W];
        got.in_range = res_user[0];
        got.last     = res_last;
        n_done++;
        if (dest_q.size() == 0) begin
          $display("%0t: result with nothing expected, actual 0x%0h", $time, got);
          errors++;
        end else begin
          want = dest_q.pop_front();
          check_field("dest_address", want.addr, got.addr);
          check_field("out_byte0", want.b0, got.b0);
          check_field("out_byte1", want.b1, got.b1);
          check_field("out_byte2", want.b2, got.b2);
          check_field("in_range", want.in_range, got.in_range);
          check_field("last_pixel", want.last, got.last);
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("pixel_rotation_address_generator regression: fail");
      $finish;
    end
  end

  // Result side: stall in random bursts
  initial begin : result_sink
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(99, 0) < stall_pct) begin
        res_ready <= 1'b0;
        repeat ($urandom_range(13, 1)) @(posedge clk_i);
      end
      res_ready <= 1'b1;
    end
  end

  // Offer one pixel, with an optional idle burst first, and hold until transfer
  task automatic push_pixel(input logic [PIX_W-1:0] pix, input bit typed,
                            input pix_result_t want);
    cfg_we <= 1'b0;
    if (!calm && $urandom_range(99, 0) < gap_pct) begin
      src_valid <= 1'b0;
      repeat ($urandom_range(13, 1)) @(posedge clk_i);
    end
    src_valid <= 1'b1;
    src_data  <= pix;
    row_typed <= typed;
    row_want  <= want;
    n_sent++;
    @(posedge clk_i);
    while (!src_ready) @(posedge clk_i);
  endtask

  // Drop valid and wait until every result is back
  task automatic settle();
    src_valid <= 1'b0;
    while (n_done < n_sent) @(posedge clk_i);
  endtask

  task automatic set_reg(input cfg_reg_e idx, input longint value);
    settle();
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value[CFG_DATA_W-1:0];
    @(posedge clk_i);
  endtask

  function automatic void add_write(input cfg_reg_e idx, input longint value);
    stim_row_t r;
    r.is_write = 1'b1;
    r.reg_idx  = idx;
    r.value    = value;
    r.pix      = '0;
    r.typed    = 1'b0;
    r.want     = '0;
    table_q.push_back(r);
  endfunction

  function automatic void add_pix(input logic [PIX_W-1:0] pix, input bit typed,
                                  input logic [ADDR_W-1:0] addr, input bit in_range,
                                  input bit last);
    stim_row_t r;
    r.is_write = 1'b0;
    r.reg_idx  = CFG_COS;
    r.value    = 0;
    r.pix      = pix;
    r.typed    = typed;
    r.want     = {addr, pix[BYTE_W-1:0], pix[BYTE_W +: BYTE_W], pix[2*BYTE_W +: BYTE_W],
                  in_range, last};
    table_q.push_back(r);
  endfunction

  // Directed table: reset state, zero sizes, identity raster, truncation, extremes
  function automatic void build_table();
    // reset settings: a 1x1 frame mapped onto itself
    add_pix(24'h000000, 1'b1, 0, 1'b1, 1'b1);
    add_pix(24'hFFFFFF, 1'b1, 0, 1'b1, 1'b1);
    add_pix(24'h5AC3A5, 1'b1, 0, 1'b1, 1'b1);
    // zero width and height act as one
    add_write(CFG_SRC_WIDTH, 0);
    add_write(CFG_SRC_HEIGHT, 0);
    add_pix(24'h123456, 1'b1, 0, 1'b1, 1'b1);
    // identity 4x2 frame, stride 12 bytes
    add_write(CFG_SRC_WIDTH, 4);
    add_write(CFG_SRC_HEIGHT, 2);
    add_write(CFG_DST_WIDTH, 4);
    add_write(CFG_DST_HEIGHT, 2);
    for (int i = 0; i < 8; i++)
      add_pix(PIX_W'(32'h00A01000 + i * 32'h00010203), 1'b1, ADDR_W'((i % 4) * 3 + (i / 4) * 12),
              1'b1, i == 7);
    // half turn with the box shifted back into range
    add_write(CFG_COS, -16384);
    add_write(CFG_X_OFFSET, -3 * TRIG_ONE);
    add_write(CFG_Y_OFFSET, -TRIG_ONE);
    for (int i = 0; i < 4; i++)
      add_pix(PIX_W'(32'h00F0E0D0 ^ (i << 4)), 1'b0, 0, 1'b0, 1'b0);
    // negative fraction truncates toward zero, not down
    add_write(CFG_COS, 16384);
    add_write(CFG_X_OFFSET, TRIG_ONE / 2);
    add_write(CFG_Y_OFFSET, 0);
    add_write(CFG_SRC_WIDTH, 1);
    add_write(CFG_SRC_HEIGHT, 1);
    add_pix(24'h0F0F0F, 1'b0, 0, 1'b0, 1'b0);
    add_pix(24'hF0F0F0, 1'b0, 0, 1'b0, 1'b0);
    // largest destination, address beyond 28 bits
    add_write(CFG_DST_WIDTH, DIM_MAX);
    add_write(CFG_DST_HEIGHT, DIM_MAX);
    add_write(CFG_X_OFFSET, -16382 * TRIG_ONE);
    add_write(CFG_Y_OFFSET, -16382 * TRIG_ONE);
    add_pix(24'h800001, 1'b0, 0, 1'b0, 1'b0);
    // offset extremes push the pixel out of range
    add_write(CFG_X_OFFSET, -268435456);
    add_write(CFG_Y_OFFSET, 268435455);
    add_pix(24'h7FFFFE, 1'b1, 0, 1'b0, 1'b1);
    // full-scale trig codes
    add_write(CFG_COS, -32768);
    add_write(CFG_SIN, 32767);
    add_write(CFG_X_OFFSET, 0);
    add_write(CFG_Y_OFFSET, 0);
    add_write(CFG_SRC_WIDTH, 3);
    for (int i = 0; i < 3; i++)
      add_pix(PIX_W'(32'h00C0FFEE >> i), 1'b0, 0, 1'b0, 1'b0);
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(3, 0))
      0, 1:    return 0;
      2:       return 15;
      default: return 40;
    endcase
  endfunction

  function automatic longint pick_dim();
    case ($urandom_range(9, 0))
      0:       return 0;
      1:       return DIM_MAX;
      2:       return 8192;
      3:       return $urandom_range(DIM_MAX, 0);
      default: return $urandom_range(20, 1);
    endcase
  endfunction

  // Rotate a w x h frame by deg with a fitted bounding box, then stream pixels
  task automatic run_rotation(input int w, input int h, input int deg, input int count);
    real    a;
    longint c, s, px, py, xmin, xmax, ymin, ymax, dw, dh;
    a = deg * PI / 180.0;
    c = $rtoi($floor($cos(a) * TRIG_ONE + 0.5));
    s = $rtoi($floor($sin(a) * TRIG_ONE + 0.5));
    xmin = 0; xmax = 0; ymin = 0; ymax = 0;
    for (int k = 0; k < 4; k++) begin
      px = ((k & 1) ? w - 1 : 0) * c - ((k & 2) ? h - 1 : 0) * s;
      py = ((k & 1) ? w - 1 : 0) * s + ((k & 2) ? h - 1 : 0) * c;
      if (px < xmin) xmin = px;
      if (px > xmax) xmax = px;
      if (py < ymin) ymin = py;
      if (py > ymax) ymax = py;
    end
    dw = (xmax - xmin) / TRIG_ONE + 1;
    dh = (ymax - ymin) / TRIG_ONE + 1;
    // now and then trim or widen the box by one
    if ($urandom_range(3, 0) == 0) dw = dw + $urandom_range(2, 0) - 1;
    if ($urandom_range(3, 0) == 0) dh = dh + $urandom_range(2, 0) - 1;
    if (dw > DIM_MAX) dw = DIM_MAX;
    if (dh > DIM_MAX) dh = DIM_MAX;
    set_reg(CFG_COS, c);
    set_reg(CFG_SIN, s);
    set_reg(CFG_X_OFFSET, xmin);
    set_reg(CFG_Y_OFFSET, ymin);
    set_reg(CFG_SRC_WIDTH, w);
    set_reg(CFG_SRC_HEIGHT, h);
    set_reg(CFG_DST_WIDTH, dw);
    set_reg(CFG_DST_HEIGHT, dh);
    for (int i = 0; i < count; i++)
      push_pixel(PIX_W'($urandom), 1'b0, '0);
  endtask

  // Arbitrary register codes over the whole field ranges
  task automatic run_noise(input int count);
    set_reg(CFG_COS, $urandom);
    set_reg(CFG_SIN, $urandom);
    set_reg(CFG_X_OFFSET, $urandom_range(1, 0) ? $urandom : -$urandom_range(400000, 0));
    set_reg(CFG_Y_OFFSET, $urandom_range(1, 0) ? $urandom : -$urandom_range(400000, 0));
    set_reg(CFG_SRC_WIDTH, pick_dim());
    set_reg(CFG_SRC_HEIGHT, pick_dim());
    set_reg(CFG_DST_WIDTH, pick_dim());
    set_reg(CFG_DST_HEIGHT, pick_dim());
    for (int i = 0; i < count; i++)
      push_pixel(PIX_W'($urandom), 1'b0, '0);
  endtask

  initial begin : stimulus
    int unsigned base;
    int          w, h, deg, count, phase;
    build_table();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    gap_pct   = 15;
    stall_pct = 15;
    foreach (table_q[i]) begin
      if (table_q[i].is_write)
        set_reg(table_q[i].reg_idx, table_q[i].value);
      else
        push_pixel(table_q[i].pix, table_q[i].typed, table_q[i].want);
    end

    // random phases: mostly fitted rotations, some arbitrary settings
    base  = n_sent;
    phase = 0;
    while (n_sent - base < RAND_ITEMS) begin
      calm      = RAND_ITEMS - (n_sent - base) < CALM_ITEMS;
      gap_pct   = pick_pct();
      stall_pct = pick_pct();
      if (phase % 5 == 4) begin
        run_noise($urandom_range(30, 8));
      end else begin
        if ($urandom_range(7, 0) == 0) begin
          w = $urandom_range(300, 1);
          h = $urandom_range(2, 1);
        end else begin
          w = $urandom_range(16, 1);
          h = $urandom_range(8, 1);
        end
        deg   = $urandom_range(3, 0) == 0 ? 90 * $urandom_range(3, 0) : $urandom_range(359, 0);
        count = w * h * $urandom_range(2, 1) + $urandom_range(w, 0);
        if (count > 400) count = 400;
        run_rotation(w, h, deg, count);
      end
      phase++;
    end

    // drain and let the pipeline run dry
    settle();
    repeat (16) @(posedge clk_i);
    if (dest_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, dest_q.size());
      errors++;
    end
    if (errors == 0)
      $display("pixel_rotation_address_generator regression: pass");
    else
      $display("pixel_rotation_address_generator regression: fail");
    $finish;
  end

endmodule
